// ===== hw/rtl/curvature_speed_limiter_core_macros.svh =====
// assertion helpers for the curvature speed limiter
`ifndef CURVATURE_SPEED_LIMITER_CORE_MACROS_SVH
`define CURVATURE_SPEED_LIMITER_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define CSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/csl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg
// shared types, constants and register indexes of the curvature speed limiter
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam int ArcW   = 24;
    localparam int CurvW  = 22;
    localparam int SpeedW = 16;
    localparam int AccW   = 12;
    localparam int ThrW   = 21;
    localparam int PrevW  = 5;
    localparam int SumW   = 23;
    localparam int NumW   = 46;
    localparam int QuoW   = 32;
    localparam int MaxPreviewDefault = 16;

    localparam logic [1:0] REG_SOFT = 2'd0;
    localparam logic [1:0] REG_HARD = 2'd1;
    localparam logic [1:0] REG_THR  = 2'd2;
    localparam logic [1:0] REG_PREV = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG,
        ST_DIV,
        ST_SQRT,
        ST_NEXT,
        ST_MERGE,
        ST_DRAIN,
        ST_EMIT,
        ST_ERR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_point;   // capture input item
        logic first_point;  // set base from input
        logic seg_start;    // prepare operands of one limit
        logic sel_pref;     // 0: hard limit, 1: preferred limit
        logic div_step;
        logic sqrt_step;
        logic store_result;
        logic merge_step;   // fold new segment into held window entries
        logic push;
        logic pop_load;     // load head entry to output
        logic shift_step;
        logic err_load;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_last;
        logic have_first;
        logic div_done;
        logic sqrt_done;
        logic merge_done;
        logic shift_done;
        logic win_ready;    // count reached window length
        logic empty;
    } stat_t;

endpackage : csl_pkg
`default_nettype wire

// ===== hw/rtl/csl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_ctrl
// sequencer: divide, square root, window merge and result draining
// ----------------------------------------------------------------------------
module csl_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            out_busy,
    output csl_pkg::cmd_t        cmd,
    input  wire csl_pkg::stat_t  stat
);

    csl_pkg::state_t state_reg, state_next;
    logic pref_reg, pref_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csl_pkg::ST_IDLE;
            pref_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pref_reg  <= pref_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        pref_next  = pref_reg;
        cmd        = '0;
        cmd.sel_pref = pref_reg;
        s_ready    = 1'b0;
        case (state_reg)
            csl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_point = 1'b1;
                    state_next = csl_pkg::ST_SEG;
                end
            end
            csl_pkg::ST_SEG: begin
                if (!stat.have_first) begin
                    if (stat.is_last) begin
                        state_next = csl_pkg::ST_ERR;
                    end else begin
                        cmd.first_point = 1'b1;
                        state_next = csl_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.seg_start = 1'b1;
                    state_next = csl_pkg::ST_DIV;
                end
            end
            csl_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = csl_pkg::ST_SQRT;
            end
            csl_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done) state_next = csl_pkg::ST_NEXT;
            end
            csl_pkg::ST_NEXT: begin
                cmd.store_result = 1'b1;
                if (!pref_reg) begin
                    // second pass for the preferred limit starts from the segment state
                    pref_next = 1'b1;
                    state_next = csl_pkg::ST_SEG;
                end else begin
                    pref_next = 1'b0;
                    state_next = csl_pkg::ST_MERGE;
                end
            end
            csl_pkg::ST_MERGE: begin
                cmd.merge_step = 1'b1;
                if (stat.merge_done) begin
                    cmd.push = 1'b1;
                    state_next = csl_pkg::ST_DRAIN;
                end
            end
            csl_pkg::ST_DRAIN: begin
                if (stat.empty || !(stat.win_ready || stat.is_last)) begin
                    cmd.commit = 1'b1;
                    state_next = csl_pkg::ST_IDLE;
                end else if (!out_busy) begin
                    cmd.pop_load = 1'b1;
                    state_next = csl_pkg::ST_EMIT;
                end
            end
            csl_pkg::ST_EMIT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done) state_next = csl_pkg::ST_DRAIN;
            end
            csl_pkg::ST_ERR: begin
                if (!out_busy) begin
                    cmd.err_load = 1'b1;
                    state_next = csl_pkg::ST_IDLE;
                end
            end
            default: state_next = csl_pkg::ST_IDLE;
        endcase
    end

endmodule : csl_ctrl
`default_nettype wire

// ===== hw/rtl/csl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_datapath
// point registers, radix-2 divider, bit-serial square root and segment window
// ----------------------------------------------------------------------------
`include "curvature_speed_limiter_core_macros.svh"
module csl_datapath #(
    parameter int MAX_PREVIEW = csl_pkg::MaxPreviewDefault
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire csl_pkg::cmd_t                 cmd,
    output csl_pkg::stat_t                     stat,
    input  wire logic [csl_pkg::ArcW-1:0]      s_arc_length,
    input  wire logic signed [csl_pkg::CurvW-1:0] s_curvature,
    input  wire logic                          s_path_end,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [csl_pkg::ThrW-1:0]      cfg_data,
    output logic                               out_busy,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [csl_pkg::ArcW-1:0]           m_segment_end,
    output logic [csl_pkg::SpeedW-1:0]         m_speed_hard,
    output logic [csl_pkg::SpeedW-1:0]         m_speed_preferred,
    output logic                               m_too_few_points,
    output logic                               m_segment_last
);

    localparam int IdxW = (MAX_PREVIEW > 1) ? $clog2(MAX_PREVIEW) : 1;
    localparam int CntW = $clog2(MAX_PREVIEW + 1);
    localparam int EntW = csl_pkg::ArcW + 2 * csl_pkg::SpeedW;
    localparam int DivCntW = $clog2(csl_pkg::NumW + 1);

    // configuration registers
    logic [csl_pkg::AccW-1:0]  soft_reg, hard_reg;
    logic [csl_pkg::ThrW-1:0]  thr_reg;
    logic [csl_pkg::PrevW-1:0] prev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soft_reg <= csl_pkg::AccW'(512);
            hard_reg <= csl_pkg::AccW'(768);
            thr_reg  <= '0;
            prev_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                csl_pkg::REG_SOFT: soft_reg <= cfg_data[csl_pkg::AccW-1:0];
                csl_pkg::REG_HARD: hard_reg <= cfg_data[csl_pkg::AccW-1:0];
                csl_pkg::REG_THR:  thr_reg  <= cfg_data;
                csl_pkg::REG_PREV: prev_reg <= cfg_data[csl_pkg::PrevW-1:0];
                default: ;
            endcase
        end
    end

    // path state
    logic have_first_reg;
    logic [csl_pkg::ArcW-1:0] base_reg, arc_reg;
    logic signed [csl_pkg::CurvW-1:0] prior_k_reg, k_reg;
    logic last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            base_reg       <= '0;
            prior_k_reg    <= '0;
        end else begin
            if (cmd.first_point) begin
                have_first_reg <= 1'b1;
                base_reg       <= arc_reg;
                prior_k_reg    <= k_reg;
            end
            if (cmd.commit) begin
                prior_k_reg <= k_reg;
                if (last_reg) have_first_reg <= 1'b0;
            end
            if (cmd.err_load) have_first_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            arc_reg  <= s_arc_length;
            k_reg    <= s_curvature;
            last_reg <= s_path_end;
        end
    end

    // segment curvature magnitude and small flag
    logic signed [csl_pkg::SumW-1:0] sum_w;
    logic [csl_pkg::SumW-1:0] s_mag;
    logic small_w;
    logic [csl_pkg::AccW-1:0] lim_w;
    assign sum_w = csl_pkg::SumW'(prior_k_reg) + csl_pkg::SumW'(k_reg);
    assign s_mag = sum_w[csl_pkg::SumW-1] ? csl_pkg::SumW'(-sum_w) : sum_w;
    assign small_w = {1'b0, s_mag} < {1'b0, thr_reg, 1'b0};
    assign lim_w = !cmd.sel_pref ? hard_reg :
                   ((soft_reg < hard_reg) ? soft_reg : hard_reg);

    // restoring divider, one quotient bit per cycle
    logic [csl_pkg::NumW-1:0]   num_reg;
    logic [csl_pkg::SumW:0]     rem_reg;
    logic [csl_pkg::SumW-1:0]   den_reg;
    logic [DivCntW-1:0]         dcnt_reg;
    logic                       zero_reg;
    logic [csl_pkg::SumW:0]     rem_sh;
    logic [csl_pkg::NumW-1:0]   n_base;
    logic [csl_pkg::NumW-1:0]   n_init;

    assign n_base = csl_pkg::NumW'(lim_w) << 29;
    assign n_init = small_w ? csl_pkg::NumW'((n_base << 4) + (n_base << 2)) : n_base;
    assign rem_sh = {rem_reg[csl_pkg::SumW-1:0], num_reg[csl_pkg::NumW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.seg_start) begin
            num_reg  <= n_init;
            rem_reg  <= '0;
            den_reg  <= s_mag;
            zero_reg <= (s_mag == '0);
            dcnt_reg <= DivCntW'(csl_pkg::NumW);
        end else if (cmd.div_step && dcnt_reg != '0) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                num_reg <= {num_reg[csl_pkg::NumW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[csl_pkg::NumW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // quotient saturates when it needs more than 32 bits or the divisor is zero
    logic sat_w;
    assign sat_w = zero_reg || (num_reg[csl_pkg::NumW-1:csl_pkg::QuoW] != '0);

    // bit-serial square root, one result bit per cycle, msb first
    logic [csl_pkg::SpeedW-1:0] root_reg;
    logic [4:0]                 scnt_reg;
    logic [csl_pkg::SpeedW-1:0] trial_w;
    logic [csl_pkg::QuoW-1:0]   trial_sq;
    assign trial_w  = root_reg | (csl_pkg::SpeedW'(1) << 4'(scnt_reg - 5'd1));
    assign trial_sq = trial_w * trial_w;

    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            root_reg <= '0;
            scnt_reg <= 5'd16;
        end else if (cmd.sqrt_step && scnt_reg != '0) begin
            if (trial_sq <= num_reg[csl_pkg::QuoW-1:0]) root_reg <= trial_w;
            scnt_reg <= scnt_reg - 1'b1;
        end
    end

    logic [csl_pkg::SpeedW-1:0] speed_w;
    assign speed_w = sat_w ? '1 : root_reg;

    logic [csl_pkg::SpeedW-1:0] v_hard_reg, v_pref_reg;
    always_ff @(posedge aclk) begin
        if (cmd.store_result) begin
            if (cmd.sel_pref) v_pref_reg <= speed_w;
            else              v_hard_reg <= speed_w;
        end
    end

    // window store and walk counter
    logic [EntW-1:0] win_mem [MAX_PREVIEW];
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] walk_reg;
    logic [CntW-1:0] win_len;
    logic [IdxW-1:0] walk_idx;
    logic [csl_pkg::ArcW-1:0] seg_end_w;
    logic [EntW-1:0] walk_ent;

    assign win_len = (prev_reg == '0) ? CntW'(1) :
                     (int'(prev_reg) > MAX_PREVIEW) ? CntW'(MAX_PREVIEW) :
                     CntW'(prev_reg);
    assign walk_idx  = walk_reg[IdxW-1:0];
    assign seg_end_w = (arc_reg > base_reg) ? arc_reg - base_reg : '0;
    assign walk_ent  = win_mem[walk_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            walk_reg  <= '0;
        end else begin
            if (cmd.merge_step) begin
                if (walk_reg < count_reg) walk_reg <= walk_reg + 1'b1;
                else walk_reg <= CntW'(1);
                if (cmd.push && count_reg < CntW'(MAX_PREVIEW))
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.pop_load) walk_reg <= CntW'(1);
            if (cmd.shift_step) begin
                if (walk_reg < count_reg) walk_reg <= walk_reg + 1'b1;
                else begin
                    walk_reg  <= '0;
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (cmd.commit) begin
                walk_reg <= '0;
                if (last_reg) count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.merge_step && walk_reg < count_reg) begin
            if (walk_ent[csl_pkg::SpeedW-1:0] > v_pref_reg)
                win_mem[walk_idx] <= {walk_ent[EntW-1:csl_pkg::SpeedW], v_pref_reg};
        end else if (cmd.push && count_reg < CntW'(MAX_PREVIEW)) begin
            win_mem[count_reg[IdxW-1:0]] <= {seg_end_w, v_hard_reg, v_pref_reg};
        end else if (cmd.shift_step && walk_reg < count_reg) begin
            win_mem[IdxW'(walk_reg - 1'b1)] <= walk_ent;
        end
    end

    // output register
    logic m_valid_reg;
    logic [csl_pkg::ArcW-1:0] m_end_reg;
    logic [csl_pkg::SpeedW-1:0] m_hard_reg, m_pref_reg;
    logic m_err_reg, m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.pop_load || cmd.err_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop_load) begin
            {m_end_reg, m_hard_reg, m_pref_reg} <= win_mem[0];
            m_err_reg  <= 1'b0;
            m_last_reg <= last_reg && (count_reg == CntW'(1));
        end else if (cmd.err_load) begin
            m_end_reg  <= '0;
            m_hard_reg <= '0;
            m_pref_reg <= '0;
            m_err_reg  <= 1'b1;
            m_last_reg <= 1'b1;
        end
    end

    assign out_busy          = m_valid_reg && !m_ready;
    assign m_valid           = m_valid_reg;
    assign m_segment_end     = m_end_reg;
    assign m_speed_hard      = m_hard_reg;
    assign m_speed_preferred = m_pref_reg;
    assign m_too_few_points  = m_err_reg;
    assign m_segment_last    = m_last_reg;

    // status to controller
    always_comb begin
        stat            = '0;
        stat.is_last    = last_reg;
        stat.have_first = have_first_reg;
        stat.div_done   = (dcnt_reg == DivCntW'(1));
        stat.sqrt_done  = (scnt_reg == 5'd1);
        stat.merge_done = (walk_reg >= count_reg);
        stat.shift_done = (walk_reg >= count_reg);
        stat.win_ready  = (count_reg >= win_len);
        stat.empty      = (count_reg == '0);
    end

    `CSL_ASSERT(a_count_bound, count_reg <= CntW'(MAX_PREVIEW), "window count overflow")
    `CSL_ASSERT_NEXT(a_pop_valid, cmd.pop_load, m_valid_reg, "pop did not raise valid")
    `CSL_ASSERT(a_pop_nonempty, !cmd.pop_load || count_reg != '0, "pop from empty window")

endmodule : csl_datapath
`default_nettype wire

// ===== hw/rtl/curvature_speed_limiter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// curvature_speed_limiter_core
// lateral acceleration speed limits per path segment with forward preview min
// ----------------------------------------------------------------------------
// One path point is taken at a time. A point that closes a segment runs two
// limits through a shared restoring divider and a bit-serial square root,
// then walks the window store once per cycle (up to MAX_PREVIEW entries);
// each emitted result passes the drain state and a shift pass over the held
// entries. The next point is accepted only once the previous one is through;
// the two divides take most of that time. No clearing pass follows reset.
module curvature_speed_limiter_core #(
    parameter int MAX_PREVIEW = csl_pkg::MaxPreviewDefault
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [csl_pkg::ArcW-1:0]          s_arc_length,
    input  wire logic signed [csl_pkg::CurvW-1:0]  s_curvature,
    input  wire logic                              s_path_end,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [csl_pkg::ArcW-1:0]               m_segment_end,
    output logic [csl_pkg::SpeedW-1:0]             m_speed_hard,
    output logic [csl_pkg::SpeedW-1:0]             m_speed_preferred,
    output logic                                   m_too_few_points,
    output logic                                   m_segment_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [csl_pkg::ThrW-1:0]          cfg_data
);

    csl_pkg::cmd_t  cmd;
    csl_pkg::stat_t stat;
    logic out_busy;

    assign cfg_ready = 1'b1;

    csl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .cmd      (cmd),
        .stat     (stat)
    );

    csl_datapath #(.MAX_PREVIEW(MAX_PREVIEW)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_arc_length      (s_arc_length),
        .s_curvature       (s_curvature),
        .s_path_end        (s_path_end),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_busy          (out_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_segment_end     (m_segment_end),
        .m_speed_hard      (m_speed_hard),
        .m_speed_preferred (m_speed_preferred),
        .m_too_few_points  (m_too_few_points),
        .m_segment_last    (m_segment_last)
    );

endmodule : curvature_speed_limiter_core
`default_nettype wire
